@@ rtl/core/plfd_pkg.sv @@
// Package with the shared types and constants of the sync-word frame deframer.
`timescale 1ns / 1ps

package plfd_pkg;

  localparam logic [31:0] SYNC_RESET = 32'hAA55_C33C;
  localparam logic [7:0]  MIN_LEN    = 8'd2;
  localparam logic [7:0]  POS_ID     = 8'd0;
  localparam logic [7:0]  POS_LEN    = 8'd1;
  localparam logic [7:0]  POS_DATA0  = 8'd2;

  typedef enum logic [2:0] {
    PH_SYNC0 = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_SYNC2 = 3'd2,
    PH_SYNC3 = 3'd3,
    PH_ID    = 3'd4,
    PH_LEN   = 3'd5,
    PH_DATA  = 3'd6
  } plfd_phase_t;

  typedef struct packed {
    logic       bad_length;
    logic       last;
    logic [7:0] byte_pos;
    logic [7:0] msg_byte;
  } plfd_result_t;

endpackage

@@ rtl/core/preamble_length_frame_deframer.sv @@
// Top level: hunts for a sync word and emits the length-prefixed message bytes that follow.
// A message byte is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one received byte per cycle while the skid entry is empty; the phase compare and position
// counter are combinational, and a two-entry output stage lets input continue until the skid entry fills.
// Reset (rst, synchronous, active high) restarts the hunt at the first sync byte,
// clears the length and position, empties the output stage and reloads the sync word.
`timescale 1ns / 1ps

module preamble_length_frame_deframer
  import plfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,     // sync_pattern, first sync byte in bits 31..24
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // msg_byte [7:0], byte_pos [15:8]
  output logic        m_axis_tlast,    // last
  output logic        m_axis_tuser     // bad_length
);

  logic [31:0]  sync_pattern;
  plfd_phase_t  phase, phase_next;
  logic [7:0]   frame_len, frame_len_next;
  logic [7:0]   pos_count, pos_count_next;

  plfd_result_t res;
  logic         res_valid;
  logic [7:0]   sync_byte;
  logic         data_fin;
  logic         in_xfer;

  plfd_result_t out_res, skid_res;
  logic         out_valid, skid_valid;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern <= SYNC_RESET;
    end else if (cfg_wr_en) begin
      sync_pattern <= cfg_wr_data;
    end
  end

  always_comb begin
    unique case (phase)
      PH_SYNC1: sync_byte = sync_pattern[23:16];
      PH_SYNC2: sync_byte = sync_pattern[15:8];
      PH_SYNC3: sync_byte = sync_pattern[7:0];
      default:  sync_byte = sync_pattern[31:24];
    endcase
  end

  assign data_fin = ({1'b0, pos_count} + 9'd1) >= {1'b0, frame_len};

  always_comb begin
    phase_next     = phase;
    frame_len_next = frame_len;
    pos_count_next = pos_count;
    res_valid      = 1'b0;
    res.msg_byte   = s_axis_tdata;
    res.byte_pos   = POS_ID;
    res.last       = 1'b0;
    res.bad_length = 1'b0;
    unique case (phase)
      PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
        phase_next = (s_axis_tdata == sync_byte) ? plfd_phase_t'(phase + 3'd1) : PH_SYNC0;
      end
      PH_ID: begin
        res_valid  = 1'b1;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        res_valid    = 1'b1;
        res.byte_pos = POS_LEN;
        if (s_axis_tdata <= MIN_LEN) begin
          // A length of two ends the message here; anything shorter is flagged as a bad length and also ends it.
          res.last       = 1'b1;
          res.bad_length = (s_axis_tdata < MIN_LEN);
          phase_next     = PH_SYNC0;
          frame_len_next = '0;
          pos_count_next = '0;
        end else begin
          phase_next     = PH_DATA;
          frame_len_next = s_axis_tdata;
          pos_count_next = POS_DATA0;
        end
      end
      PH_DATA: begin
        res_valid    = 1'b1;
        res.byte_pos = pos_count;
        res.last     = data_fin;
        if (data_fin) begin
          phase_next     = PH_SYNC0;
          frame_len_next = '0;
          pos_count_next = '0;
        end else begin
          pos_count_next = pos_count + 8'd1;
        end
      end
      default: begin
        // The first sync byte, and the unused phase code, which behaves the same.
        phase_next = (s_axis_tdata == sync_byte) ? PH_SYNC1 : PH_SYNC0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SYNC0;
      frame_len <= '0;
      pos_count <= '0;
    end else if (in_xfer) begin
      phase     <= phase_next;
      frame_len <= frame_len_next;
      pos_count <= pos_count_next;
    end
  end

  // Output register plus one skid entry; the input stalls only when the skid entry is full.
  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      out_valid  <= skid_valid || (in_xfer && res_valid);
      skid_valid <= 1'b0;
    end else if (in_xfer && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (in_xfer && res_valid) begin
      skid_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.byte_pos, out_res.msg_byte};
  assign m_axis_tlast  = out_res.last;
  assign m_axis_tuser  = out_res.bad_length;

endmodule

@@ rtl/core/plfd_checker.sv @@
// Port-level checker for the deframer, bound to the top level.
`timescale 1ns / 1ps

module plfd_checker
  import plfd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // A flagged length always closes the message at the length position.
  a_bad_len_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tlast && m_axis_tdata[15:8] == POS_LEN && m_axis_tdata[7:0] < MIN_LEN))
    else $error("bad length transfer is not a final length byte below the minimum");

  // A good frame that ends on its length byte must have declared a length of two.
  a_short_frame: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast && !m_axis_tuser && m_axis_tdata[15:8] == POS_LEN) |->
      (m_axis_tdata[7:0] == MIN_LEN))
    else $error("frame closed on its length byte with a length other than two");

  // The message id is never the last byte.
  a_id_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[15:8] == POS_ID) |-> (!m_axis_tlast && !m_axis_tuser))
    else $error("id byte marked last or bad");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
       && $stable(m_axis_tuser)))
    else $error("output transfer changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind preamble_length_frame_deframer plfd_checker u_plfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

@@ bench/preamble_length_frame_deframer_tb.sv @@
// Testbench for the sync-word deframer: byte streams in, message bytes checked against a predictor.
`timescale 1ns / 1ps

module preamble_length_frame_deframer_tb;
  import plfd_pkg::*;

  localparam int DRAIN_PAD   = 8;
  localparam int PHASE_ITEMS = 355;

  typedef struct packed {
    logic [7:0]   data;
    logic         typed;    // expected result written in the row, not predicted
    logic         has_res;
    plfd_result_t res;
  } stim_row_t;

  localparam plfd_result_t NO_RES = '0;

  localparam stim_row_t DIRECTED [24] = '{
    // Default sync word, id 00, length two: the length byte closes the message.
    '{8'hAA, 1'b1, 1'b0, NO_RES},
    '{8'h55, 1'b1, 1'b0, NO_RES},
    '{8'hC3, 1'b1, 1'b0, NO_RES},
    '{8'h3C, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, POS_ID, 8'h00}},
    '{8'h02, 1'b1, 1'b1, '{1'b0, 1'b1, POS_LEN, 8'h02}},
    // The repeated first byte breaks the hunt and is not taken as a fresh start,
    // so the rest of the sync word goes by unmatched.
    '{8'hAA, 1'b1, 1'b0, NO_RES},
    '{8'hAA, 1'b1, 1'b0, NO_RES},
    '{8'h55, 1'b1, 1'b0, NO_RES},
    '{8'hC3, 1'b1, 1'b0, NO_RES},
    '{8'h3C, 1'b1, 1'b0, NO_RES},
    // Id FF with length zero: flagged as a bad length, which closes the message.
    '{8'hAA, 1'b1, 1'b0, NO_RES},
    '{8'h55, 1'b1, 1'b0, NO_RES},
    '{8'hC3, 1'b1, 1'b0, NO_RES},
    '{8'h3C, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b1, '{1'b0, 1'b0, POS_ID, 8'hFF}},
    '{8'h00, 1'b1, 1'b1, '{1'b1, 1'b1, POS_LEN, 8'h00}},
    // Length three: a single data byte, left to the predictor.
    '{8'hAA, 1'b1, 1'b0, NO_RES},
    '{8'h55, 1'b1, 1'b0, NO_RES},
    '{8'hC3, 1'b1, 1'b0, NO_RES},
    '{8'h3C, 1'b1, 1'b0, NO_RES},
    '{8'h5A, 1'b0, 1'b0, NO_RES},
    '{8'h03, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic [31:0] cfg_wr_data   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;   // msg_byte [7:0], byte_pos [15:8]
  logic        m_axis_tlast;   // last
  logic        m_axis_tuser;   // bad_length

  // Row tags travel with the data so the monitor sees the tag of the accepted byte.
  logic         drv_typed   = 1'b0;
  logic         drv_has_res = 1'b0;
  plfd_result_t drv_res     = '0;

  // Predictor state.
  logic [31:0]  mdl_sync;
  plfd_phase_t  mdl_phase;
  logic [7:0]   mdl_len;
  logic [7:0]   mdl_pos;
  plfd_result_t pending_bytes [$];

  int          errors     = 0;
  int          sent       = 0;
  bit          tx_calm    = 1'b0;
  bit          rx_calm    = 1'b0;
  int          stall_left = 0;
  logic [31:0] cur_sync   = SYNC_RESET;

  preamble_length_frame_deframer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] sync_at(input logic [31:0] pat, input int k);
    return pat[31 - 8 * k -: 8];
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    return (r < 80) ? $urandom_range(1, 3) : $urandom_range(4, 30);
  endfunction

  function automatic void restart_hunt();
    mdl_phase = PH_SYNC0;
    mdl_len   = '0;
    mdl_pos   = '0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output plfd_result_t r);
    logic [2:0] idx;
    r = '0;
    r.msg_byte = b;
    case (mdl_phase)
      PH_ID: begin
        r.byte_pos = POS_ID;
        mdl_phase  = PH_LEN;
        return 1'b1;
      end
      PH_LEN: begin
        r.byte_pos = POS_LEN;
        if (b <= MIN_LEN) begin
          r.last       = 1'b1;
          r.bad_length = (b < MIN_LEN);
          restart_hunt();
        end else begin
          mdl_len   = b;
          mdl_pos   = POS_DATA0;
          mdl_phase = PH_DATA;
        end
        return 1'b1;
      end
      PH_DATA: begin
        r.byte_pos = mdl_pos;
        r.last     = ({1'b0, mdl_pos} + 9'd1 >= {1'b0, mdl_len});
        if (r.last) restart_hunt();
        else mdl_pos = mdl_pos + 8'd1;
        return 1'b1;
      end
      default: begin
        // Sync hunt; a phase code outside the known ones hunts for the first byte.
        idx = (mdl_phase <= PH_SYNC3) ? 3'(mdl_phase) : 3'd0;
        if (b == sync_at(mdl_sync, idx)) mdl_phase = plfd_phase_t'(idx + 3'd1);
        else mdl_phase = PH_SYNC0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    plfd_result_t r;
    plfd_result_t act;
    plfd_result_t want;
    bit           has;
    if (rst) begin
      mdl_sync = SYNC_RESET;
      restart_hunt();
    end else begin
      if (cfg_wr_en) mdl_sync = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        has = deframe_byte(s_axis_tdata, r);
        if (drv_typed) begin
          has = drv_has_res;
          r   = drv_res;
        end
        if (has) pending_bytes.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act.msg_byte   = m_axis_tdata[7:0];
        act.byte_pos   = m_axis_tdata[15:8];
        act.last       = m_axis_tlast;
        act.bad_length = m_axis_tuser;
        if (pending_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual %h", $time, act);
        end else begin
          want = pending_bytes.pop_front();
          check_field("msg_byte", want.msg_byte, act.msg_byte);
          check_field("byte_pos", want.byte_pos, act.byte_pos);
          check_field("last", 8'(want.last), 8'(act.last));
          check_field("bad_length", 8'(want.bad_length), 8'(act.bad_length));
        end
      end
    end
  end

  // Receiver: ready most of the time, with stalls of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= pause_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_row(input stim_row_t row);
    int gap;
    gap = (!tx_calm && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.data;
    drv_typed     <= row.typed;
    drv_has_res   <= row.has_res;
    drv_res       <= row.res;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_rand();
    send_row('{8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_RES});
  endtask

  task automatic send_sync(input int count);
    for (int k = 0; k < count; k++) send_row('{sync_at(cur_sync, k), 1'b0, 1'b0, NO_RES});
  endtask

  // Holds the sender until every message byte has come out, then waits out DRAIN_PAD for
  // sync bytes still in flight.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_sync(input logic [31:0] pat);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pat;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_sync     = pat;
  endtask

  task automatic run_phase(input logic [31:0] pat, input bit with_max);
    int  stop;
    int  kind;
    int  r;
    int  len;
    bit  max_done;
    wait_drained();
    write_sync(pat);
    rx_calm  = ($urandom_range(0, 3) == 0);
    max_done = !with_max;
    stop     = sent + PHASE_ITEMS;
    while (sent < stop) begin
      kind    = $urandom_range(0, 99);
      tx_calm = ($urandom_range(0, 3) == 0);
      if (kind < 72) begin
        send_sync(4);
        send_rand();
        r = $urandom_range(0, 99);
        if (!max_done) len = 255;
        else if (r < 8) len = $urandom_range(0, 1);
        else if (r < 11) len = 255;
        else if (r < 16) len = $urandom_range(13, 254);
        else len = $urandom_range(2, 12);
        max_done = 1'b1;
        send_row('{8'(len), 1'b0, 1'b0, NO_RES});
        for (int k = 2; k < len; k++) send_rand();
      end else if (kind < 85) begin
        // A sync word cut short by an arbitrary byte.
        send_sync($urandom_range(1, 3));
        send_rand();
      end else begin
        repeat ($urandom_range(1, 6)) send_rand();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_row(DIRECTED[i]);

    run_phase(32'h0000_0000, 1'b1);
    run_phase(32'hFFFF_FFFF, 1'b0);
    run_phase($urandom, 1'b0);
    run_phase(SYNC_RESET, 1'b0);
    run_phase($urandom, 1'b0);

    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
